/* rtl/adam_parameter_update_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Adam parameter update unit
// Shared forms of the concurrent checks, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ADAM_PARAMETER_UPDATE_UNIT_ASSERT_SVH
`define ADAM_PARAMETER_UPDATE_UNIT_ASSERT_SVH

// same-cycle implication
`define APU_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("apu check failed");

// next-cycle implication
`define APU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("apu check failed");

// implication after a fixed number of cycles
`define APU_ASSERT_DELAY(lbl, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(n) (cons)) \
        else $error("apu check failed");

`endif

/* rtl/apu_pkg.sv */
// ----------------------------------------------------------------------------
// Adam parameter update package
// Shared constants, command codes and the sideband carried down the pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apu_pkg;

    localparam int ELEMENT_DEPTH = 4096;
    localparam int ADDR_W        = $clog2(ELEMENT_DEPTH);

    localparam int DIV_STEPS  = 32;
    localparam int SQRT_STEPS = 32;
    localparam int QUO_STEPS  = 35;
    localparam int LATENCY    = 4 + (DIV_STEPS + 1) + (SQRT_STEPS + 1) + (QUO_STEPS + 1);

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic [2:0] CFG_STEP_SIZE      = 3'd0;
    localparam logic [2:0] CFG_FIRST_DECAY    = 3'd1;
    localparam logic [2:0] CFG_SECOND_DECAY   = 3'd2;
    localparam logic [2:0] CFG_STABILITY_TERM = 3'd3;

    localparam logic [1:0] KIND_UPDATE = 2'd0;
    localparam logic [1:0] KIND_TICK   = 2'd1;
    localparam logic [1:0] KIND_EARLY  = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic        neg;
        logic        sat;
        logic [31:0] param;
        logic [31:0] aux;
    } apu_side_t;

endpackage

/* rtl/apu_corr_div.sv */
// ----------------------------------------------------------------------------
// Bias correction divider
// Two radix-2 restoring dividers in lock step giving m_hat and v_hat, capped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apu_corr_div
    import apu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  apu_side_t   in_side,
    input  logic [31:0] m_mag,
    input  logic [32:0] d1,
    input  logic [31:0] v_val,
    input  logic [32:0] d2,
    output logic        out_valid,
    output apu_side_t   out_side,
    output logic [31:0] out_vh
);

    logic        vld_reg  [DIV_STEPS+1];
    apu_side_t   side_reg [DIV_STEPS+1];
    logic [32:0] mrem_reg [DIV_STEPS+1];
    logic [32:0] vrem_reg [DIV_STEPS+1];
    logic [31:0] mq_reg   [DIV_STEPS+1];
    logic [31:0] vq_reg   [DIV_STEPS+1];
    logic        mov_reg  [DIV_STEPS+1];
    logic        vov_reg  [DIV_STEPS+1];
    logic [32:0] d1_reg   [DIV_STEPS+1];
    logic [32:0] d2_reg   [DIV_STEPS+1];

    logic        m_cap;
    logic        v_cap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        mrem_reg[0] <= {1'b0, m_mag};
        vrem_reg[0] <= {1'b0, v_val};
        mq_reg[0]   <= '0;
        vq_reg[0]   <= '0;
        mov_reg[0]  <= ({1'b0, m_mag} >= d1);
        vov_reg[0]  <= ({1'b0, v_val} >= d2);
        d1_reg[0]   <= d1;
        d2_reg[0]   <= d2;
    end

    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_step
        logic [33:0] mt;
        logic [33:0] vt;

        assign mt = {mrem_reg[k-1], 1'b0};
        assign vt = {vrem_reg[k-1], 1'b0};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_reg[k-1];
            mov_reg[k]  <= mov_reg[k-1];
            vov_reg[k]  <= vov_reg[k-1];
            d1_reg[k]   <= d1_reg[k-1];
            d2_reg[k]   <= d2_reg[k-1];
            if (mt >= {1'b0, d1_reg[k-1]})
            begin
                mrem_reg[k] <= 33'(mt - {1'b0, d1_reg[k-1]});
                mq_reg[k]   <= {mq_reg[k-1][30:0], 1'b1};
            end
            else
            begin
                mrem_reg[k] <= mt[32:0];
                mq_reg[k]   <= {mq_reg[k-1][30:0], 1'b0};
            end
            if (vt >= {1'b0, d2_reg[k-1]})
            begin
                vrem_reg[k] <= 33'(vt - {1'b0, d2_reg[k-1]});
                vq_reg[k]   <= {vq_reg[k-1][30:0], 1'b1};
            end
            else
            begin
                vrem_reg[k] <= vt[32:0];
                vq_reg[k]   <= {vq_reg[k-1][30:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        m_cap     = mov_reg[DIV_STEPS] || (mq_reg[DIV_STEPS] > 32'h8000_0000);
        v_cap     = vov_reg[DIV_STEPS];
        out_valid = vld_reg[DIV_STEPS];
        out_side  = side_reg[DIV_STEPS];
        out_side.sat = side_reg[DIV_STEPS].sat || m_cap || v_cap;
        out_side.aux = m_cap ? 32'h8000_0000 : mq_reg[DIV_STEPS];
        out_vh    = v_cap ? 32'hFFFF_FFFF : vq_reg[DIV_STEPS];
    end

endmodule

/* rtl/apu_sqrt.sv */
// ----------------------------------------------------------------------------
// Pipelined square root
// Digit-by-digit integer root of v_hat scaled by 2^32, one result bit a stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apu_sqrt
    import apu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  apu_side_t   in_side,
    input  logic [31:0] vh,
    output logic        out_valid,
    output apu_side_t   out_side,
    output logic [31:0] root
);

    logic        vld_reg  [SQRT_STEPS+1];
    apu_side_t   side_reg [SQRT_STEPS+1];
    logic [34:0] rem_reg  [SQRT_STEPS+1];
    logic [31:0] root_reg [SQRT_STEPS+1];
    logic [63:0] x_reg    [SQRT_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        rem_reg[0]  <= '0;
        root_reg[0] <= '0;
        x_reg[0]    <= {vh, 32'h0};
    end

    for (genvar k = 1; k <= SQRT_STEPS; k++)
    begin : g_step
        logic [34:0] r2;
        logic [34:0] trial;

        assign r2    = {rem_reg[k-1][32:0], x_reg[k-1][63:62]};
        assign trial = {1'b0, root_reg[k-1], 2'b01};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_reg[k-1];
            x_reg[k]    <= {x_reg[k-1][61:0], 2'b00};
            if (r2 >= trial)
            begin
                rem_reg[k]  <= r2 - trial;
                root_reg[k] <= {root_reg[k-1][30:0], 1'b1};
            end
            else
            begin
                rem_reg[k]  <= r2;
                root_reg[k] <= {root_reg[k-1][30:0], 1'b0};
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS];
    assign out_side  = side_reg[SQRT_STEPS];
    assign root      = root_reg[SQRT_STEPS];

endmodule

/* rtl/apu_quo_div.sv */
// ----------------------------------------------------------------------------
// Step quotient divider
// Radix-2 restoring divide of alpha * m_hat by the root term, capped at 2^34.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apu_quo_div
    import apu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  apu_side_t   in_side,
    input  logic [62:0] num,
    input  logic [40:0] den,
    output logic        out_valid,
    output apu_side_t   out_side,
    output logic [34:0] quo
);

    logic        vld_reg  [QUO_STEPS+1];
    apu_side_t   side_reg [QUO_STEPS+1];
    logic [40:0] rem_reg  [QUO_STEPS+1];
    logic [34:0] q_reg    [QUO_STEPS+1];
    logic [34:0] n_reg    [QUO_STEPS+1];
    logic [40:0] den_reg  [QUO_STEPS+1];
    logic        ov_reg   [QUO_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= in_side;
        rem_reg[0]  <= {13'h0, num[62:35]};
        q_reg[0]    <= '0;
        n_reg[0]    <= num[34:0];
        den_reg[0]  <= den;
        ov_reg[0]   <= ({13'h0, num} >= {den, 35'h0});
    end

    for (genvar k = 1; k <= QUO_STEPS; k++)
    begin : g_step
        logic [41:0] t;

        assign t = {rem_reg[k-1], n_reg[k-1][34]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_reg[k-1];
            n_reg[k]    <= {n_reg[k-1][33:0], 1'b0};
            den_reg[k]  <= den_reg[k-1];
            ov_reg[k]   <= ov_reg[k-1];
            if (t >= {1'b0, den_reg[k-1]})
            begin
                rem_reg[k] <= 41'(t - {1'b0, den_reg[k-1]});
                q_reg[k]   <= {q_reg[k-1][33:0], 1'b1};
            end
            else
            begin
                rem_reg[k] <= t[40:0];
                q_reg[k]   <= {q_reg[k-1][33:0], 1'b0};
            end
        end
    end

    localparam logic [34:0] QUO_CAP = 35'h4_0000_0000;

    assign out_valid = vld_reg[QUO_STEPS];
    assign out_side  = side_reg[QUO_STEPS];
    assign quo = (ov_reg[QUO_STEPS] || (q_reg[QUO_STEPS] > QUO_CAP)) ? QUO_CAP
                                                                      : q_reg[QUO_STEPS];

endmodule

/* rtl/adam_parameter_update_unit.sv */
// ----------------------------------------------------------------------------
// Adam parameter update unit
// Fixed-point element-wise Adam step with moment memories and bias correction.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at each clock edge with start high
//   and busy low; busy stays low, so a command may be issued every cycle.
//   cmd selects a timestep tick or an update of one element, whose moments
//   live in two single-port-write synchronous memories indexed by
//   element_index.
//   Each command yields one result on new_param, not_started and saturated, marked
//   by done for one cycle. Results leave in command order.
//   The moments are read the cycle a command is taken and written back the
//   next; back-to-back updates of one element forward the fresh moments.
//   The correction divider, square root and step divider each resolve one
//   bit per stage, which sets the latency; throughput is one command a cycle.
//   Configuration writes go on the cfg channel, always ready; the user must issue
//   them only while no command is in flight, as the block does not enforce it.
//   Reset clears the pipeline and the tick flag and sets the timestep powers to one;
//   moment memories are not cleared. The receiver cannot stall the result stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adam_parameter_update_unit
    import apu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cmd,
    input  logic [11:0] element_index,
    input  logic        first_use,
    input  logic signed [31:0] grad_value,
    input  logic signed [31:0] param_value,
    output logic        done,
    output logic signed [31:0] new_param,
    output logic        not_started,
    output logic        saturated,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

`include "adam_parameter_update_unit_assert.svh"

    logic [23:0] step_size_reg;
    logic [15:0] first_decay_reg;
    logic [15:0] second_decay_reg;
    logic [31:0] stability_term_reg;
    logic [32:0] beta1_power_reg;
    logic [32:0] beta1_power_next;
    logic [32:0] beta2_power_reg;
    logic [32:0] beta2_power_next;
    logic        tick_seen_reg;

    logic [31:0] m_mem [ELEMENT_DEPTH];
    logic [31:0] v_mem [ELEMENT_DEPTH];
    logic [31:0] m_rd_reg;
    logic [31:0] v_rd_reg;

    logic        accept;
    logic [ADDR_W-1:0] rd_addr;
    logic signed [63:0] gsq_full;
    logic signed [17:0] om1;
    logic [16:0]        om2;
    logic [32:0] d1_now;
    logic [32:0] d2_now;

    logic              a_valid_reg;
    apu_side_t         a_side_reg;
    logic [ADDR_W-1:0] a_idx_reg;
    logic              a_fresh_reg;
    logic [46:0]       a_gsq_reg;
    logic signed [49:0] a_pg_reg;
    logic [32:0]       a_d1_reg;
    logic [32:0]       a_d2_reg;

    logic signed [31:0] m_old;
    logic [31:0]        v_old;
    logic signed [50:0] mt;
    logic signed [31:0] m_new;
    logic [63:0]        v_sum;
    logic [31:0]        v_new;
    logic               v_sat;
    logic               wr_en;
    logic               fwd;
    apu_side_t          b_side_next;

    logic              b_valid_reg;
    apu_side_t         b_side_reg;
    logic [ADDR_W-1:0] b_idx_reg;
    logic              b_wr_reg;
    logic [31:0]       b_m_reg;
    logic [31:0]       b_v_reg;
    logic [31:0]       b_mmag_reg;
    logic [32:0]       b_d1_reg;
    logic [32:0]       b_d2_reg;

    logic        c_valid;
    apu_side_t   c_side;
    logic [31:0] c_vh;
    logic        s_valid;
    apu_side_t   s_side;
    logic [31:0] s_root;

    logic [40:0] den_sum;
    logic [54:0] num_prod;
    logic        d_valid_reg;
    apu_side_t   d_side_reg;
    logic [40:0] d_den_reg;
    logic [62:0] d_num_reg;

    logic        q_valid;
    apu_side_t   q_side;
    logic [34:0] q_quo;
    logic signed [36:0] delta;
    logic signed [36:0] res;
    logic               res_sat;

    logic        done_reg;
    logic [31:0] new_param_reg;
    logic        not_started_reg;
    logic        saturated_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign rd_addr   = element_index[ADDR_W-1:0];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg      <= 24'd16777;
            first_decay_reg    <= 16'd58982;
            second_decay_reg   <= 16'd65470;
            stability_term_reg <= 32'd43;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_STEP_SIZE:      step_size_reg      <= cfg_data[23:0];
                CFG_FIRST_DECAY:    first_decay_reg    <= cfg_data[15:0];
                CFG_SECOND_DECAY:   second_decay_reg   <= cfg_data[15:0];
                CFG_STABILITY_TERM: stability_term_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // timestep powers
    always_comb
    begin
        beta1_power_next = 33'((beta1_power_reg * {33'h0, first_decay_reg}) >> 16);
        beta2_power_next = 33'((beta2_power_reg * {33'h0, second_decay_reg}) >> 16);
        d1_now = 33'h1_0000_0000 - beta1_power_reg;
        d2_now = 33'h1_0000_0000 - beta2_power_reg;
        if (d1_now == '0)
        begin
            d1_now = 33'd1;
        end
        if (d2_now == '0)
        begin
            d2_now = 33'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta1_power_reg <= 33'h1_0000_0000;
            beta2_power_reg <= 33'h1_0000_0000;
            tick_seen_reg   <= 1'b0;
        end
        else if (accept && (cmd == CMD_TICK))
        begin
            beta1_power_reg <= beta1_power_next;
            beta2_power_reg <= beta2_power_next;
            tick_seen_reg   <= 1'b1;
        end
    end

    // capture stage
    always_comb
    begin
        gsq_full = grad_value * grad_value;
        om1 = {1'b0, 17'(17'h1_0000 - {1'b0, first_decay_reg})};
        om2 = 17'(17'h1_0000 - {1'b0, second_decay_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        a_side_reg.kind  <= (cmd == CMD_TICK) ? KIND_TICK
                          : (tick_seen_reg ? KIND_UPDATE : KIND_EARLY);
        a_side_reg.neg   <= 1'b0;
        a_side_reg.sat   <= 1'b0;
        a_side_reg.param <= param_value;
        a_side_reg.aux   <= '0;
        a_idx_reg        <= rd_addr;
        a_fresh_reg      <= first_use;
        a_gsq_reg        <= gsq_full[62:16];
        a_pg_reg         <= om1 * grad_value;
        a_d1_reg         <= d1_now;
        a_d2_reg         <= d2_now;
    end

    // moment memories: read on capture, written back in the next cycle
    always_ff @(posedge clk)
    begin
        m_rd_reg <= m_mem[rd_addr];
        v_rd_reg <= v_mem[rd_addr];
        if (wr_en)
        begin
            m_mem[a_idx_reg] <= m_new;
            v_mem[a_idx_reg] <= v_new;
        end
    end

    // moment update with forwarding from the previous write
    always_comb
    begin
        wr_en = a_valid_reg && (a_side_reg.kind == KIND_UPDATE);
        fwd   = b_wr_reg && (b_idx_reg == a_idx_reg);
        if (a_fresh_reg)
        begin
            m_old = '0;
            v_old = '0;
        end
        else if (fwd)
        begin
            m_old = b_m_reg;
            v_old = b_v_reg;
        end
        else
        begin
            m_old = m_rd_reg;
            v_old = v_rd_reg;
        end
        mt    = 51'($signed({2'b00, first_decay_reg}) * m_old) + 51'(a_pg_reg);
        m_new = mt[47:16];
        v_sum = 64'({32'h0, v_old} * {48'h0, second_decay_reg})
              + 64'({47'h0, om2} * {17'h0, a_gsq_reg});
        v_sat = |v_sum[63:48];
        v_new = v_sat ? 32'hFFFF_FFFF : v_sum[47:16];
        b_side_next     = a_side_reg;
        b_side_next.neg = m_new[31];
        b_side_next.sat = v_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_wr_reg    <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
            b_wr_reg    <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        b_side_reg <= b_side_next;
        b_idx_reg  <= a_idx_reg;
        b_m_reg    <= m_new;
        b_v_reg    <= v_new;
        b_mmag_reg <= m_new[31] ? 32'(-m_new) : m_new;
        b_d1_reg   <= a_d1_reg;
        b_d2_reg   <= a_d2_reg;
    end

    apu_corr_div u_corr_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (b_valid_reg),
        .in_side   (b_side_reg),
        .m_mag     (b_mmag_reg),
        .d1        (b_d1_reg),
        .v_val     (b_v_reg),
        .d2        (b_d2_reg),
        .out_valid (c_valid),
        .out_side  (c_side),
        .out_vh    (c_vh)
    );

    apu_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (c_valid),
        .in_side   (c_side),
        .vh        (c_vh),
        .out_valid (s_valid),
        .out_side  (s_side),
        .root      (s_root)
    );

    // denominator and numerator of the step
    always_comb
    begin
        den_sum = {1'b0, s_root, 8'h00} + {9'h0, stability_term_reg};
        if (den_sum == '0)
        begin
            den_sum = 41'd1;
        end
        num_prod = 55'({31'h0, step_size_reg} * {23'h0, s_side.aux});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        d_side_reg <= s_side;
        d_den_reg  <= den_sum;
        d_num_reg  <= {num_prod, 8'h00};
    end

    apu_quo_div u_quo_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_valid_reg),
        .in_side   (d_side_reg),
        .num       (d_num_reg),
        .den       (d_den_reg),
        .out_valid (q_valid),
        .out_side  (q_side),
        .quo       (q_quo)
    );

    // apply the step and clip
    always_comb
    begin
        delta   = q_side.neg ? -$signed({2'b00, q_quo}) : $signed({2'b00, q_quo});
        res     = $signed({{5{q_side.param[31]}}, q_side.param}) - delta;
        res_sat = !((res[36:31] == 6'h00) || (res[36:31] == 6'h3F));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= q_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        case (q_side.kind)
            KIND_TICK:
            begin
                new_param_reg   <= '0;
                not_started_reg <= 1'b0;
                saturated_reg   <= 1'b0;
            end
            KIND_EARLY:
            begin
                new_param_reg   <= q_side.param;
                not_started_reg <= 1'b1;
                saturated_reg   <= 1'b0;
            end
            default:
            begin
                new_param_reg   <= res_sat ? (res[36] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                           : res[31:0];
                not_started_reg <= 1'b0;
                saturated_reg   <= q_side.sat || res_sat;
            end
        endcase
    end

    assign done        = done_reg;
    assign new_param   = new_param_reg;
    assign not_started = not_started_reg;
    assign saturated   = saturated_reg;

    `APU_ASSERT_DELAY(a_fixed_latency, accept, LATENCY, done)
    `APU_ASSERT_IMPLIES(a_early_clean, done && not_started, !saturated)
    `APU_ASSERT_NEXT(a_tick_marks, accept && (cmd == CMD_TICK), tick_seen_reg)
    `APU_ASSERT_NEXT(a_power_falls, 1'b1, beta1_power_reg <= $past(beta1_power_reg))

endmodule
